@@ sv/dst_pkg.sv @@
// shared constants and types for the divisor sum core
package dst_pkg;

  // fixed field widths of the beats
  localparam int unsigned VALUE_W = 40;
  localparam int unsigned SUM_W = 44;

  // internal saturating product width
  localparam int unsigned ACC_W = 64;

  // default number of value bits taken from the input beat
  localparam int unsigned VALUE_BITS_DEF = 40;

  typedef enum logic [0:0] {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } dst_op_e;

  typedef struct packed {
    logic    start;
    dst_op_e op;
  } dst_req_t;

endpackage

@@ sv/dst_unit.sv @@
// shared bit-serial divide / saturating multiply unit built around one adder
module dst_unit #(
  parameter int unsigned NB = dst_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dst_pkg::dst_req_t         req_i,
  input  logic [dst_pkg::ACC_W-1:0] a_i,
  input  logic [NB:0]               b_i,
  output logic                      done_o,
  output logic [NB-1:0]             quo_o,
  output logic [NB-1:0]             rem_o,
  output logic [dst_pkg::ACC_W-1:0] prod_o
);
  import dst_pkg::*;

  localparam int unsigned MW = NB + 1;
  localparam int unsigned CW = $clog2(MW + 1);
  localparam int unsigned AW = ACC_W + 2;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            sat_q, sat_d;
  dst_op_e         op_q, op_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] y_q, y_d;
  logic [MW-1:0]   z_q, z_d;
  logic [NB-1:0]   r_q, r_d;

  logic [AW-1:0]   lhs, rhs, res;
  logic            sub;
  logic            last;

  // the one adder: subtract for divide, shift-add for multiply
  always_comb begin
    if (op_q == OP_DIV) begin
      lhs = AW'({r_q, acc_q[NB-1]});
      rhs = AW'(y_q[NB-1:0]);
      sub = 1'b1;
    end else begin
      lhs = {1'b0, acc_q, 1'b0};
      rhs = z_q[MW-1] ? AW'(y_q) : '0;
      sub = 1'b0;
    end
    res = lhs + (sub ? ~rhs : rhs) + AW'(sub);
  end

  assign last = (op_q == OP_DIV) ? (cnt_q == CW'(NB - 1)) : (cnt_q == CW'(MW - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    y_d    = y_q;
    z_d    = z_q;
    r_d    = r_q;
    if (req_i.start) begin
      op_d   = req_i.op;
      busy_d = 1'b1;
      cnt_d  = '0;
      sat_d  = 1'b0;
      r_d    = '0;
      z_d    = b_i;
      if (req_i.op == OP_DIV) begin
        y_d   = ACC_W'(b_i[NB-1:0]);
        acc_d = ACC_W'(a_i[NB-1:0]);
      end else begin
        y_d   = a_i;
        acc_d = '0;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (op_q == OP_DIV) begin
        // restoring step: no borrow means the divisor fits
        if (!res[AW-1]) begin
          r_d = res[NB-1:0];
        end else begin
          r_d = lhs[NB-1:0];
        end
        acc_d = ACC_W'({acc_q[NB-2:0], ~res[AW-1]});
      end else begin
        sat_d = sat_q | (res[AW-1:ACC_W] != '0);
        acc_d = res[ACC_W-1:0];
        z_d   = z_q << 1;
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    acc_q <= acc_d;
    y_q   <= y_d;
    z_q   <= z_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q[NB-1:0];
  assign rem_o  = r_q;
  assign prod_o = sat_q ? '1 : acc_q;

endmodule

@@ sv/divisor_sum_trial_division_core.sv @@
// divisor sum core: trial division sequencer around one shared divide/multiply unit
// a divide runs VALUE_BITS bit steps in the unit and a multiply VALUE_BITS+1; the sequencer
//   tries trial divisors up to the square root of the remaining cofactor, at most
//   2^(VALUE_BITS/2) of them
// throughput: one item at a time; input stalls until the sequencer is idle again
// reset: rst_ni clears the sequencer, the unit control and the output valid at once
module divisor_sum_trial_division_core #(
  parameter int unsigned VALUE_BITS = dst_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dst_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dst_pkg::SUM_W-1:0]   divisor_sum_o,
  output logic                        is_perfect_o,
  output logic                        is_prime_o
);
  import dst_pkg::*;

  localparam int unsigned NB = VALUE_BITS;
  localparam int unsigned MW = NB + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,  // rem / d, test d <= quotient and divisibility
    S_PW    = 7'b0000100,  // pw * d for the next power
    S_INNER = 7'b0001000,  // rem / d while d keeps dividing
    S_SUM   = 7'b0010000,  // sum * term, saturating
    S_LAST  = 7'b0100000,  // sum * (rem + 1) for a leftover prime
    S_DONE  = 7'b1000000   // hand the result to the output register
  } state_e;

  state_e          state_q, state_d;
  logic            go_q, go_d;
  logic            zero_q, zero_d;
  logic [NB-1:0]   n_q, n_d;       // masked input value
  logic [NB-1:0]   rem_q, rem_d;   // remaining cofactor
  logic [NB-1:0]   d_q, d_d;       // trial divisor
  logic [NB-1:0]   pw_q, pw_d;     // current power of d
  logic [MW-1:0]   term_q, term_d; // 1 + d + ... + d^k
  logic [ACC_W-1:0] sum_q, sum_d;  // running product, saturating

  logic            out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_sum_q, out_sum_d;
  logic            out_perf_q, out_perf_d;
  logic            out_prime_q, out_prime_d;

  logic [NB-1:0]   n_in;
  dst_req_t        req;
  logic [ACC_W-1:0] op_a;
  logic [MW-1:0]   op_b;
  logic            u_done;
  logic [NB-1:0]   u_quo;
  logic [NB-1:0]   u_rem;
  logic [ACC_W-1:0] u_prod;
  logic            load_out;

  // only the low VALUE_BITS of the beat count
  if (NB <= VALUE_W) begin : g_trunc
    assign n_in = value_i[NB-1:0];
  end else begin : g_ext
    assign n_in = {{(NB - VALUE_W){1'b0}}, value_i};
  end

  // operands follow the state just entered; go_q is registered alongside the state and starts the unit
  always_comb begin
    unique case (state_q)
      S_PW: begin
        req.op = OP_MUL;
        op_a   = ACC_W'(pw_q);
        op_b   = MW'(d_q);
      end
      S_SUM: begin
        req.op = OP_MUL;
        op_a   = sum_q;
        op_b   = term_q;
      end
      S_LAST: begin
        req.op = OP_MUL;
        op_a   = sum_q;
        op_b   = MW'(rem_q) + MW'(1);
      end
      default: begin
        req.op = OP_DIV;
        op_a   = ACC_W'(rem_q);
        op_b   = MW'(d_q);
      end
    endcase
    req.start = go_q;
  end

  dst_unit #(
    .NB(NB)
  ) u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .a_i   (op_a),
    .b_i   (op_b),
    .done_o(u_done),
    .quo_o (u_quo),
    .rem_o (u_rem),
    .prod_o(u_prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    zero_d  = zero_q;
    n_d     = n_q;
    rem_d   = rem_q;
    d_d     = d_q;
    pw_d    = pw_q;
    term_d  = term_q;
    sum_d   = sum_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d    = n_in;
          rem_d  = n_in;
          d_d    = NB'(2);
          zero_d = (n_in == '0);
          if (n_in == '0) begin
            sum_d   = '0;
            state_d = S_DONE;
          end else begin
            sum_d   = ACC_W'(1);
            state_d = S_CHK;
            go_d    = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (u_done) begin
          if (d_q <= u_quo) begin
            if (u_rem == '0) begin
              // d divides: start collecting its powers
              rem_d   = u_quo;
              pw_d    = NB'(1);
              term_d  = MW'(1);
              state_d = S_PW;
            end else begin
              d_d = d_q + NB'(1);
            end
            go_d = 1'b1;
          end else if (rem_q > NB'(1)) begin
            state_d = S_LAST;
            go_d    = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PW: begin
        if (u_done) begin
          pw_d    = u_prod[NB-1:0];
          term_d  = term_q + MW'(u_prod[NB-1:0]);
          state_d = S_INNER;
          go_d    = 1'b1;
        end
      end
      S_INNER: begin
        if (u_done) begin
          if (u_rem == '0) begin
            rem_d   = u_quo;
            state_d = S_PW;
          end else begin
            state_d = S_SUM;
          end
          go_d = 1'b1;
        end
      end
      S_SUM: begin
        if (u_done) begin
          sum_d   = u_prod;
          d_d     = d_q + NB'(1);
          state_d = S_CHK;
          go_d    = 1'b1;
        end
      end
      S_LAST: begin
        if (u_done) begin
          sum_d   = u_prod;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register; flags use the full ACC_W sum rather than the clamped output, so a saturated sum sets neither
  always_comb begin
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_perf_d  = out_perf_q;
    out_prime_d = out_prime_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_sum_d   = (sum_q[ACC_W-1:SUM_W] != '0) ? '1 : sum_q[SUM_W-1:0];
      out_perf_d  = !zero_q && (sum_q == (ACC_W'(n_q) << 1));
      out_prime_d = !zero_q && (sum_q == (ACC_W'(n_q) + ACC_W'(1)));
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q      <= zero_d;
    n_q         <= n_d;
    rem_q       <= rem_d;
    d_q         <= d_d;
    pw_q        <= pw_d;
    term_q      <= term_d;
    sum_q       <= sum_d;
    out_sum_q   <= out_sum_d;
    out_perf_q  <= out_perf_d;
    out_prime_q <= out_prime_d;
  end

  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_sum_q;
  assign is_perfect_o  = out_perf_q;
  assign is_prime_o    = out_prime_q;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the divisor sum core: predicted sums against result beats
module testbench;
  import dst_pkg::*;

  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [63:0] SUM_MASK = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] ACC_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // random values are kept to at most RAND_TRIAL_CAP trial divisors so the run stays short
  localparam int unsigned RAND_TRIAL_CAP = 160;
  localparam int unsigned RANDOM_ITEMS = 50;
  localparam int unsigned STEADY_ITEMS = 20;
  localparam int unsigned PRESSURE_ITEMS = 8;
  localparam int unsigned PRESSURE_HOLD = 4000;
  // slowest directed item runs about a thousand trial divisors
  localparam int unsigned SILENT_LIMIT = 600000;
  localparam int unsigned END_DRAIN = 200;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             perfect;
    logic             prime;
  } sigma_beat_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] tx_value;
  logic               out_valid;
  logic               out_stall;
  logic [SUM_W-1:0]   divisor_sum;
  logic               is_perfect;
  logic               is_prime;

  sigma_beat_t pending_sums[$];
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_request;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned primes_seen;
  int unsigned perfects_seen;
  int unsigned input_stall_cycles;

  divisor_sum_trial_division_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .value_i      (tx_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .divisor_sum_o(divisor_sum),
    .is_perfect_o (is_perfect),
    .is_prime_o   (is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] sat_product(logic [63:0] a, logic [63:0] b);
    if (a != 64'd0 && b > ACC_MAX / a) return ACC_MAX;
    return a * b;
  endfunction

  // sigma by trial division; gives up (returns 0) past trial_cap divisors
  function automatic bit compute_sigma(input logic [VALUE_W-1:0] v, input int unsigned trial_cap,
                                       output sigma_beat_t beat);
    logic [63:0] n, rem, acc, d, pw, term;
    int unsigned trials;
    n = 64'(v) & VALUE_MASK;
    beat = '0;
    if (n == 64'd0) return 1'b1;
    rem = n;
    acc = 64'd1;
    d = 64'd2;
    trials = 0;
    while (d <= rem / d) begin
      if (trials >= trial_cap) return 1'b0;
      trials++;
      if (rem % d == 64'd0) begin
        pw = 64'd1;
        term = 64'd1;
        while (rem % d == 64'd0) begin
          rem = rem / d;
          pw = pw * d;
          term = term + pw;
        end
        acc = sat_product(acc, term);
      end
      d++;
    end
    // leftover cofactor is prime
    if (rem > 64'd1) acc = sat_product(acc, rem + 64'd1);
    beat.sum = (acc > SUM_MASK) ? SUM_MASK[SUM_W-1:0] : acc[SUM_W-1:0];
    beat.perfect = (acc == 64'd2 * n);
    beat.prime = (acc == n + 64'd1);
    return 1'b1;
  endfunction

  // mix of short raw values, smooth values over the full width and the odd zero
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [63:0] v, f, top;
    sigma_beat_t scratch;
    int unsigned kind, w;
    do begin
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        v = 64'd0;
      end else if (kind < 35) begin
        w = $urandom_range(1, 24);
        v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        if (v == 64'd0) v = 64'd1;
      end else begin
        top = 64'd1 << $urandom_range(8, VALUE_BITS);
        v = 64'd1;
        if ($urandom_range(0, 2) == 0) v = $urandom_range(100, 20000);
        repeat (48) begin
          f = $urandom_range(2, 97);
          if (v * f < top) v = v * f;
        end
      end
    end while (!compute_sigma(v[VALUE_W-1:0], RAND_TRIAL_CAP, scratch));
    return v[VALUE_W-1:0];
  endfunction

  // offer one beat, possibly after an idle burst, and log its sum once taken
  task automatic send_value(input logic [VALUE_W-1:0] v);
    sigma_beat_t beat;
    int unsigned gap;
    void'(compute_sigma(v, 32'hFFFF_FFFF, beat));
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      tx_value <= VALUE_W'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    tx_value <= v;
    do @(posedge clk); while (in_stall);
    pending_sums = {pending_sums, beat};
    items_sent++;
  endtask

  task automatic test_corner_values();
    logic [VALUE_W-1:0] corner[$] = '{
      40'd0, 40'd1, 40'd2, 40'd3, 40'd4, 40'd6, 40'd28, 40'd36, 40'd496, 40'd8128,
      40'd8191, 40'd63001, 40'd65521, 40'd131071, 40'd720720, 40'd1048573,
      40'd33550336, 40'd8589869056, 40'd137438691328, 40'd847288609443,
      40'd549755813888, 40'd1099511627775
    };
    foreach (corner[i]) send_value(corner[i]);
  endtask

  // receiver holds off long enough that the core parks a result and stalls its input
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_request = PRESSURE_HOLD;
    repeat (PRESSURE_ITEMS) send_value(VALUE_W'($urandom_range(1, 300)));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_values();
    repeat (RANDOM_ITEMS) send_value(pick_value());
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (STEADY_ITEMS) send_value(pick_value());
  endtask

  // receiver side: random stall bursts, or a long hold when asked
  initial begin
    int unsigned burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        burst = hold_request;
        hold_request = 0;
      end else if (burst == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
      end
      if (burst != 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result check against the oldest predicted sum
  always @(posedge clk) begin
    sigma_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        $error("unexpected result beat: divisor_sum %0d", divisor_sum);
        error_count++;
      end else begin
        want = pending_sums.pop_front();
        if (divisor_sum !== want.sum) begin
          $error("divisor_sum: expected %0d, got %0d", want.sum, divisor_sum);
          error_count++;
        end
        if (is_perfect !== want.perfect) begin
          $error("is_perfect: expected %0b, got %0b", want.perfect, is_perfect);
          error_count++;
        end
        if (is_prime !== want.prime) begin
          $error("is_prime: expected %0b, got %0b", want.prime, is_prime);
          error_count++;
        end
        if (want.prime) primes_seen++;
        if (want.perfect) perfects_seen++;
      end
    end
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int unsigned silent;
    silent = 0;
    while (silent < SILENT_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) silent = 0;
      else silent++;
    end
    $display("timeout: no beat moved for %0d cycles", SILENT_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    tx_value = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_request = 0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    primes_seen = 0;
    perfects_seen = 0;
    input_stall_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    test_corner_values();
    test_backpressure();
    test_random_values();
    test_steady_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("covered %0d values (zero, one, primes, perfect numbers, powers, full width)",
             items_sent);
    $display("checked %0d sums, %0d prime and %0d perfect; input held off %0d cycles",
             results_seen, primes_seen, perfects_seen, input_stall_cycles);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ divisor_sum_trial_division_core.f @@
sv/dst_pkg.sv
sv/dst_unit.sv
sv/divisor_sum_trial_division_core.sv
verif/testbench.sv
